// ----- rtl/fpha_pkg.sv -----
// ----------------------------------------------------------------------------
// fpha_pkg
// Shared types and constants for the hole allocator: table geometry, command,
// policy and status codes, and the structs that run along the cell chain.
// ----------------------------------------------------------------------------
package fpha_pkg;

  // Table geometry and field widths
  localparam int HOLE_ENTRIES = 16;
  localparam int ADDR_W       = 16;
  localparam int IDX_W        = (HOLE_ENTRIES > 1) ? $clog2(HOLE_ENTRIES) : 1;
  localparam int AMT_W        = 16;
  localparam int SLOT_W       = 4;
  localparam int PID_W        = 8;
  localparam int OADDR_W      = 16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_RSVD  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    STS_GRANTED = 2'd0,
    STS_NOFIT   = 2'd1,
    STS_LOADED  = 2'd2,
    STS_RSVD    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_PEND = 2'd2
  } ctrl_state_e;

  // Search token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic              active;
    logic              found;
    logic [IDX_W-1:0]  slot;
    logic [AMT_W-1:0]  size;
    logic [ADDR_W-1:0] start;
  } tok_t;

  // Request fields broadcast to all cells during a scan
  typedef struct packed {
    policy_e          policy;
    logic [AMT_W-1:0] need;
  } scan_t;

  // Table write broadcast: load a hole or carve a grant from one
  typedef struct packed {
    logic              load;
    logic              alloc;
    logic [IDX_W-1:0]  slot;
    logic [ADDR_W-1:0] start;
    logic [AMT_W-1:0]  amount;
  } wr_t;

endpackage

// ----- rtl/fpha_cell.sv -----
// ----------------------------------------------------------------------------
// fpha_cell
// One table entry: holds a hole, compares it against the passing search
// token and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module fpha_cell
  import fpha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  scan_t            scan_i,
  input  wr_t              wr_i,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic              valid_q;
  logic [ADDR_W-1:0] start_q;
  logic [AMT_W-1:0]  size_q;
  logic              tok_active_q;
  tok_t              tok_d;
  tok_t              tok_pl_q;
  logic              fit;
  logic              take;
  logic              hit;

  assign hit = (wr_i.slot == idx_i);
  assign fit = valid_q && (size_q >= scan_i.need);

  // Decide whether this hole beats the best one seen so far
  always_comb begin
    unique case (scan_i.policy)
      POL_BEST:  take = fit && (!tok_i.found || (size_q < tok_i.size));
      POL_WORST: take = fit && (!tok_i.found || (size_q > tok_i.size));
      default:   take = fit && !tok_i.found;
    endcase
    tok_d = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.slot  = idx_i;
      tok_d.size  = size_q;
      tok_d.start = start_q;
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_active_q <= 1'b0;
    end else begin
      tok_active_q <= tok_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_pl_q <= tok_d;
  end

  always_comb begin
    tok_o        = tok_pl_q;
    tok_o.active = tok_active_q;
  end

  // Valid bit: set on load, drop when a grant uses the hole up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.load && hit) begin
      valid_q <= 1'b1;
    end else if (wr_i.alloc && hit && (size_q == wr_i.amount) && (wr_i.amount != '0)) begin
      valid_q <= 1'b0;
    end
  end

  // Hole contents: overwrite on load, carve from the front on a grant
  always_ff @(posedge clk_i) begin
    if (wr_i.load && hit) begin
      start_q <= wr_i.start;
      size_q  <= wr_i.amount;
    end else if (wr_i.alloc && hit) begin
      start_q <= start_q + ADDR_W'(wr_i.amount);
      size_q  <= size_q - wr_i.amount;
    end
  end

endmodule

// ----- rtl/fpha_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpha_ctrl
// Sequencer: takes an item, writes loads straight into the table, launches
// the search token for allocates, applies the grant when the token leaves
// the chain and drives the output register.
// ----------------------------------------------------------------------------
module fpha_ctrl
  import fpha_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [1:0]         policy_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [15:0]        start_address_i,
  input  logic [AMT_W-1:0]   amount_i,
  input  logic [PID_W-1:0]   process_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [OADDR_W-1:0] granted_address_o,
  output logic [SLOT_W-1:0]  chosen_slot_o,
  output logic [PID_W-1:0]   owner_id_o,
  output scan_t              scan_o,
  output wr_t                wr_o,
  output tok_t               head_tok_o,
  input  tok_t               tail_tok_i
);

  ctrl_state_e        state_q, state_d;
  logic               launch_q, launch_d;
  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               res_en;
  logic               slot_in_range;
  policy_e            req_policy_q;
  logic [AMT_W-1:0]   req_need_q;
  logic [PID_W-1:0]   req_pid_q;
  status_e            res_status_d, res_status_q;
  logic [OADDR_W-1:0] res_addr_d, res_addr_q;
  logic [SLOT_W-1:0]  res_slot_d, res_slot_q;
  logic [PID_W-1:0]   res_pid_d, res_pid_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [OADDR_W-1:0] out_addr_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [PID_W-1:0]   out_pid_q;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign slot_in_range = (32'(slot_i) < 32'(HOLE_ENTRIES));

  assign scan_o.policy = req_policy_q;
  assign scan_o.need   = req_need_q;

  // Token entering the first cell
  always_comb begin
    head_tok_o        = '0;
    head_tok_o.active = launch_q;
  end

  // Next state, table writes and result formation
  always_comb begin
    state_d      = state_q;
    launch_d     = 1'b0;
    wr_o         = '0;
    res_en       = 1'b0;
    out_load     = 1'b0;
    res_status_d = STS_NOFIT;
    res_addr_d   = '0;
    res_slot_d   = '0;
    res_pid_d    = req_pid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(command_i) == CMD_LOAD) begin
            res_en    = 1'b1;
            res_pid_d = process_id_i;
            state_d   = ST_PEND;
            if (slot_in_range) begin
              wr_o.load    = 1'b1;
              wr_o.slot    = IDX_W'(slot_i);
              wr_o.start   = ADDR_W'(start_address_i);
              wr_o.amount  = amount_i;
              res_status_d = STS_LOADED;
              res_slot_d   = slot_i;
            end
          end else begin
            launch_d = 1'b1;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tail_tok_i.active) begin
          res_en  = 1'b1;
          state_d = ST_PEND;
          if (tail_tok_i.found) begin
            wr_o.alloc   = 1'b1;
            wr_o.slot    = tail_tok_i.slot;
            wr_o.amount  = req_need_q;
            res_status_d = STS_GRANTED;
            res_addr_d   = OADDR_W'(tail_tok_i.start);
            res_slot_d   = SLOT_W'(tail_tok_i.slot);
          end
        end
      end
      ST_PEND: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold request, pending result and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_policy_q <= policy_e'(policy_i);
      req_need_q   <= amount_i;
      req_pid_q    <= process_id_i;
    end
    if (res_en) begin
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
      res_slot_q   <= res_slot_d;
      res_pid_q    <= res_pid_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_slot_q   <= res_slot_q;
      out_pid_q    <= res_pid_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;
  assign chosen_slot_o     = out_slot_q;
  assign owner_id_o        = out_pid_q;

`ifndef SYNTHESIS
  // A token only leaves the chain while a scan is in progress
  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_tok_i.active |-> (state_q == ST_SCAN))
    else $error("search token left the chain outside a scan");

  // Loads and grants never hit the table in the same cycle
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_o.load && wr_o.alloc))
    else $error("load and grant written together");

  // Taking an item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block not busy after taking an item");

  // A launch is only ever issued from a scan that just started
  a_launch_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> ((state_q == ST_SCAN) && !tail_tok_i.active))
    else $error("token launched outside a fresh scan");
`endif

endmodule

// ----- rtl/fit_policy_hole_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator
// Free-hole table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A load writes its hole at the edge that
// takes the item; its result is held in a pending register and moves into the
// output register once that register is free. An allocate sends a search
// token down a row of HOLE_ENTRIES cells, one cell per cycle, each holding
// one hole; the grant is written back when the token leaves the last cell and
// its result follows the same path through the pending register. The block is
// ready for the next item once the result moves into the output register,
// even while it is still stalled there. Policy code 3 acts as first fit; ties
// go to the lowest slot.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator
  import fpha_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [1:0]         policy_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [15:0]        start_address_i,
  input  logic [AMT_W-1:0]   amount_i,
  input  logic [PID_W-1:0]   process_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [OADDR_W-1:0] granted_address_o,
  output logic [SLOT_W-1:0]  chosen_slot_o,
  output logic [PID_W-1:0]   owner_id_o
);

  scan_t scan;
  wr_t   wr;
  tok_t  tok [HOLE_ENTRIES+1];

  // Sequencer and output register
  fpha_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .policy_i          (policy_i),
    .slot_i            (slot_i),
    .start_address_i   (start_address_i),
    .amount_i          (amount_i),
    .process_id_i      (process_id_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .chosen_slot_o     (chosen_slot_o),
    .owner_id_o        (owner_id_o),
    .scan_o            (scan),
    .wr_o              (wr),
    .head_tok_o        (tok[0]),
    .tail_tok_i        (tok[HOLE_ENTRIES])
  );

  // Row of hole cells, token passed from each to the next
  for (genvar g = 0; g < HOLE_ENTRIES; g++) begin : g_cell
    fpha_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .scan_i (scan),
      .wr_i   (wr),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

endmodule

// ----- tb/sv/fit_policy_hole_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator_tb
// Drives load and allocate items into the hole allocator and checks every
// result against a predicted copy of the hole table. The table copy is
// updated at the edge that takes each item, so results are checked in order.
// Directed items cover empty tables, every fit rule, ties, wrap and field
// extremes. Random traffic, a steady stream, a long output hold-off and
// drain pauses follow.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpha_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct {
    cmd_e                cmd;
    policy_e             policy;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   start;
    logic [AMT_W-1:0]    amount;
    logic [PID_W-1:0]    pid;
  } hole_req_t;

  typedef struct {
    status_e             status;
    logic [OADDR_W-1:0]  addr;
    logic [SLOT_W-1:0]   slot;
    logic [PID_W-1:0]    owner;
  } grant_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = 1'b0;
  logic [1:0]         policy_i = '0;
  logic [SLOT_W-1:0]  slot_i = '0;
  logic [15:0]        start_address_i = '0;
  logic [AMT_W-1:0]   amount_i = '0;
  logic [PID_W-1:0]   process_id_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [OADDR_W-1:0] granted_address_o;
  logic [SLOT_W-1:0]  chosen_slot_o;
  logic [PID_W-1:0]   owner_id_o;

  // Predicted hole table
  logic               hole_live [HOLE_ENTRIES] = '{default: 1'b0};
  logic [ADDR_W-1:0]  hole_base [HOLE_ENTRIES] = '{default: '0};
  logic [AMT_W-1:0]   hole_room [HOLE_ENTRIES] = '{default: '0};

  grant_t             pending_grants [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  logic               steady_run = 1'b0;
  int                 hold_off_ask = 0;
  int                 hold_off_taken = 0;
  int                 hold_left = 0;

  fit_policy_hole_allocator uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .policy_i          (policy_i),
    .slot_i            (slot_i),
    .start_address_i   (start_address_i),
    .amount_i          (amount_i),
    .process_id_i      (process_id_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .chosen_slot_o     (chosen_slot_o),
    .owner_id_o        (owner_id_o)
  );

  always #6 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Apply one item to the table copy and return the result it should cause
  function automatic grant_t predict_grant(hole_req_t r);
    grant_t g;
    int     pick;
    g.status = STS_NOFIT;
    g.addr   = '0;
    g.slot   = '0;
    g.owner  = r.pid;
    pick     = -1;
    if (r.cmd == CMD_LOAD) begin
      if (r.slot < HOLE_ENTRIES) begin
        hole_live[r.slot] = 1'b1;
        hole_base[r.slot] = r.start;
        hole_room[r.slot] = r.amount;
        g.status = STS_LOADED;
        g.slot   = r.slot;
      end
      return g;
    end
    // Scan in slot order; only strictly better holes replace the pick
    for (int i = 0; i < HOLE_ENTRIES; i++) begin
      if (hole_live[i] && hole_room[i] >= r.amount) begin
        if (pick < 0) begin
          pick = i;
        end else if (r.policy == POL_BEST && hole_room[i] < hole_room[pick]) begin
          pick = i;
        end else if (r.policy == POL_WORST && hole_room[i] > hole_room[pick]) begin
          pick = i;
        end
      end
    end
    if (pick >= 0) begin
      g.status = STS_GRANTED;
      g.addr   = hole_base[pick];
      g.slot   = pick[SLOT_W-1:0];
      hole_base[pick] = hole_base[pick] + r.amount;
      hole_room[pick] = hole_room[pick] - r.amount;
      if (hole_room[pick] == '0 && r.amount != '0) hole_live[pick] = 1'b0;
    end
    return g;
  endfunction

  function automatic hole_req_t make_req(cmd_e cmd, policy_e pol, int slot, int start,
                                         int amount, int pid);
    hole_req_t r;
    r.cmd    = cmd;
    r.policy = pol;
    r.slot   = slot[SLOT_W-1:0];
    r.start  = start[ADDR_W-1:0];
    r.amount = amount[AMT_W-1:0];
    r.pid    = pid[PID_W-1:0];
    return r;
  endfunction

  // Offer one item, hold it until taken, then idle at random
  task automatic offer_item(hole_req_t r);
    int gap;
    in_valid_i      <= 1'b1;
    command_i       <= r.cmd;
    policy_i        <= r.policy;
    slot_i          <= r.slot;
    start_address_i <= r.start;
    amount_i        <= r.amount;
    process_id_i    <= r.pid;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_grants.push_back(predict_grant(r));
    gap = 0;
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 34) gap++;
      if ($urandom_range(0, 19) == 0) gap += $urandom_range(1, 24);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_grants.size() != 0);
  endtask

  // Build a random item; allocates mostly aim at holes that exist
  task automatic offer_random_item();
    hole_req_t         r;
    int                live_slots [$];
    logic [AMT_W-1:0]  room;
    int                roll;
    r.cmd    = ($urandom_range(0, 99) < 35) ? CMD_LOAD : CMD_ALLOC;
    r.policy = policy_e'($urandom_range(0, 3));
    r.slot   = SLOT_W'($urandom_range(0, HOLE_ENTRIES - 1));
    r.pid    = PID_W'($urandom_range(0, 255));
    roll     = $urandom_range(0, 99);
    if (r.cmd == CMD_LOAD) begin
      if (roll < 30) r.start = ADDR_W'(16'hFFFF - $urandom_range(0, 255));
      else r.start = ADDR_W'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 5) r.amount = '0;
      else if (roll < 65) r.amount = AMT_W'($urandom_range(1, 512));
      else if (roll < 90) r.amount = AMT_W'($urandom_range(0, 8191));
      else r.amount = AMT_W'($urandom_range(0, 65535));
    end else begin
      r.start = ADDR_W'($urandom_range(0, 65535));
      foreach (hole_live[i]) if (hole_live[i]) live_slots.push_back(i);
      if (live_slots.size() == 0 || roll < 10) begin
        r.amount = AMT_W'($urandom_range(0, 65535));
      end else begin
        room = hole_room[live_slots[$urandom_range(0, live_slots.size() - 1)]];
        if (roll < 25) r.amount = AMT_W'($urandom_range(0, 64));
        else if (roll < 45) r.amount = room;
        else if (roll < 85) r.amount = AMT_W'($urandom_range(0, room));
        else r.amount = AMT_W'(room + $urandom_range(1, 16));
      end
    end
    offer_item(r);
  endtask

  // Compare one taken result with the oldest expectation
  task automatic check_grant();
    grant_t want;
    if (pending_grants.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result status=%0d addr=%h slot=%0d owner=%h",
                 $time, status_o, granted_address_o, chosen_slot_o, owner_id_o);
      return;
    end
    want = pending_grants.pop_front();
    if (status_o !== want.status || granted_address_o !== want.addr ||
        chosen_slot_o !== want.slot || owner_id_o !== want.owner) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: expected status=%0d addr=%h slot=%0d owner=%h, got %0d %h %0d %h",
                 $time, want.status, want.addr, want.slot, want.owner,
                 status_o, granted_address_o, chosen_slot_o, owner_id_o);
    end
  endtask

  // Take results and drive the output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) check_grant();
    if (hold_off_ask != hold_off_taken) begin
      hold_off_taken <= hold_off_ask;
      hold_left      <= HOLD_OFF_CYCLES;
      out_stall_i    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (steady_run) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 34);
    end
  end

  // Allocate from an empty table under every rule
  task automatic test_empty_table();
    offer_item(make_req(CMD_ALLOC, POL_FIRST, 0, 0, 0, 8'h00));
    offer_item(make_req(CMD_ALLOC, POL_BEST, 0, 0, 1, 8'h01));
    offer_item(make_req(CMD_ALLOC, POL_WORST, 0, 0, 16'hFFFF, 8'hFF));
    offer_item(make_req(CMD_ALLOC, POL_RSVD, 0, 0, 16'h8000, 8'h80));
  endtask

  // Exercise each fit rule, ties, wrap, zero sizes and used-up holes
  task automatic test_fit_policies();
    offer_item(make_req(CMD_LOAD, POL_FIRST, 0, 16'h1000, 100, 8'h10));
    offer_item(make_req(CMD_LOAD, POL_FIRST, 5, 16'h2000, 40, 8'h11));
    offer_item(make_req(CMD_LOAD, POL_FIRST, 15, 16'h3000, 40, 8'h12));
    offer_item(make_req(CMD_LOAD, POL_FIRST, 9, 16'hFFF0, 300, 8'h13));
    offer_item(make_req(CMD_LOAD, POL_FIRST, 3, 16'h4000, 0, 8'h14));
    offer_item(make_req(CMD_ALLOC, POL_BEST, 0, 0, 30, 8'h20));
    offer_item(make_req(CMD_ALLOC, POL_WORST, 0, 0, 50, 8'h21));
    offer_item(make_req(CMD_ALLOC, POL_FIRST, 0, 0, 0, 8'h22));
    offer_item(make_req(CMD_ALLOC, POL_RSVD, 0, 0, 10, 8'h23));
    offer_item(make_req(CMD_ALLOC, POL_BEST, 0, 0, 0, 8'h24));
    offer_item(make_req(CMD_ALLOC, POL_FIRST, 0, 0, 90, 8'h25));
    offer_item(make_req(CMD_ALLOC, POL_WORST, 0, 0, 251, 8'h26));
  endtask

  // Drive the widest values and alternating bit patterns
  task automatic test_field_extremes();
    offer_item(make_req(CMD_LOAD, POL_RSVD, 15, 16'hFFFF, 16'hFFFF, 8'hFF));
    offer_item(make_req(CMD_ALLOC, POL_WORST, 0, 0, 16'hFFFF, 8'hAA));
    offer_item(make_req(CMD_ALLOC, POL_FIRST, 0, 0, 16'hFFFF, 8'h00));
    offer_item(make_req(CMD_LOAD, POL_BEST, 10, 16'h5555, 16'hAAAA, 8'h55));
    offer_item(make_req(CMD_ALLOC, POL_BEST, 15, 16'hFFFF, 16'h2AAA, 8'hFF));
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) offer_random_item();
  endtask

  // Run both sides with no idling at all
  task automatic test_steady_stream(int count);
    steady_run <= 1'b1;
    repeat (count) offer_random_item();
    steady_run <= 1'b0;
  endtask

  // Hold the output off while items keep coming, so the input backs up
  task automatic test_receiver_hold_off(int count);
    hold_off_ask <= hold_off_ask + 1;
    repeat (count) offer_random_item();
  endtask

  // Pause the sender until the block has nothing left in flight
  task automatic test_drain_pause(int rounds, int count);
    repeat (rounds) begin
      repeat (count) offer_random_item();
      wait_for_drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_table();
    test_fit_policies();
    test_field_extremes();
    test_random_traffic(580);
    test_steady_stream(150);
    test_receiver_hold_off(40);
    test_drain_pause(3, 20);

    // Let the last results come out, then watch for strays
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- fit_policy_hole_allocator.f -----
rtl/fpha_pkg.sv
rtl/fpha_cell.sv
rtl/fpha_ctrl.sv
rtl/fit_policy_hole_allocator.sv
tb/sv/fit_policy_hole_allocator_tb.sv
